// ===== hdl/lapedge_pkg.sv =====
// shared types and constants for the 3x3 rgb laplacian edge unit
// no dependencies; compiled first

package lapedge_pkg;

    localparam int CH_W      = 8;   // bits per color channel
    localparam int DIM_W     = 11;  // frame dimension register width
    localparam int CNT_W     = 22;  // pixel counters, holds 2047 * 2047
    localparam int REG_IDX_W = 1;   // configuration register index

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef logic [DIM_W-1:0] dim_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_t;

    // red in the top byte, blue in the bottom byte
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    // one column of the 3x3 window
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } col_t;

    // result control handed from the line store stage to the filter
    typedef struct packed {
        logic valid;
        logic border;
        logic frame_end;
    } ctrl_t;

endpackage

// ===== hdl/lapedge_if.sv =====
// pixel and edge stream channels, valid/ready handshake
// depends on lapedge_pkg

interface lapedge_in_if
    import lapedge_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            kind;
    logic [CH_W-1:0] pixel_red;
    logic [CH_W-1:0] pixel_green;
    logic [CH_W-1:0] pixel_blue;

    modport source (output valid, kind, pixel_red, pixel_green, pixel_blue, input ready);
    modport sink (input valid, kind, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface lapedge_out_if
    import lapedge_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] edge_red;
    logic [CH_W-1:0] edge_green;
    logic [CH_W-1:0] edge_blue;
    logic            frame_end;

    modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
    modport sink (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

// ===== hdl/lapedge_filter.sv =====
// 3x3 window columns, laplacian per channel with clamp, result register
// depends on lapedge_pkg and lapedge_out_if

module lapedge_filter
    import lapedge_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  col_t                 col,
    input  ctrl_t                ctrl,
    output logic                 take,
    lapedge_out_if.source        edge_chan
);

    col_t   left_reg;
    col_t   center_reg;
    pixel_t res_reg;
    logic   res_end_reg;
    logic   res_valid_reg;
    logic   res_valid_next;
    pixel_t lap;

    // eight times the center minus the neighbors, clamped to 0..255
    function automatic logic [CH_W-1:0] lap_chan(
        input logic [CH_W-1:0]         c,
        input logic [7:0][CH_W-1:0]    n
    );
        logic [CH_W+2:0]        s;
        logic signed [CH_W+3:0] d;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + (CH_W+3)'(n[i]);
        end
        d = $signed({1'b0, c, 3'b000}) - $signed({1'b0, s});
        if (d < 0)
        begin
            return '0;
        end
        else if (d > $signed((CH_W+4)'(255)))
        begin
            return {CH_W{1'b1}};
        end
        return d[CH_W-1:0];
    endfunction

    always_comb
    begin
        lap = '0;
        for (int k = 0; k < 3; k++)
        begin
            lap[k*CH_W +: CH_W] = lap_chan(center_reg.mid[k*CH_W +: CH_W],
                {left_reg.top[k*CH_W +: CH_W], left_reg.mid[k*CH_W +: CH_W],
                 left_reg.bot[k*CH_W +: CH_W], center_reg.top[k*CH_W +: CH_W],
                 center_reg.bot[k*CH_W +: CH_W], col.top[k*CH_W +: CH_W],
                 col.mid[k*CH_W +: CH_W], col.bot[k*CH_W +: CH_W]});
        end
    end

    assign take = ctrl.valid && (!res_valid_reg || edge_chan.ready);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (edge_chan.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // window shifts once per result, in result order
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_reg    <= center_reg;
            center_reg  <= col;
            res_reg     <= ctrl.border ? '0 : lap;
            res_end_reg <= ctrl.frame_end;
        end
    end

    assign edge_chan.valid      = res_valid_reg;
    assign edge_chan.edge_red   = res_reg.red;
    assign edge_chan.edge_green = res_reg.green;
    assign edge_chan.edge_blue  = res_reg.blue;
    assign edge_chan.frame_end  = res_end_reg;

`ifndef SYNTHESIS
    a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> edge_chan.valid)
        else $error("taken column gave no result");

    a_border_black: assert property (@(posedge clk) disable iff (!rst_n)
        take && ctrl.border |=> (edge_chan.edge_red == '0) && (edge_chan.edge_green == '0)
            && (edge_chan.edge_blue == '0))
        else $error("border result not black");

    a_end_kept: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (edge_chan.frame_end == $past(ctrl.frame_end)))
        else $error("frame end mark lost");
`endif

endmodule

// ===== hdl/laplacian_edge_3x3_rgb_unit.sv =====
// top level of the 3x3 rgb laplacian edge unit: counters, line store, result stage
// depends on lapedge_pkg, lapedge_if and lapedge_filter
//
//  channel     dir  handshake            word
//  pixel_chan  in   valid/ready          kind, pixel_red, pixel_green, pixel_blue
//  edge_chan   out  valid/ready          edge_red, edge_green, edge_blue, frame_end
//  cfg         in   cfg_we, no ready     cfg_index, cfg_wdata
//
//  one word per clock while no stall holds the column stage
//  the rate is set by the line store: one write and two reads per cycle
//  rst_n clears the counters and the stage valids and loads the reset dimensions;
//  the line store is not cleared; unwritten words reach only border results
//  a stall on edge_chan holds the column stage; pixel_chan keeps taking words
//  while that stage is empty, even with a result waiting in the output register

module laplacian_edge_3x3_rgb_unit
    import lapedge_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_wdata,
    lapedge_in_if.sink           pixel_chan,
    lapedge_out_if.source        edge_chan
);

    localparam int   COL_W   = $clog2(MAX_WIDTH);
    localparam int   CW      = (COL_W > DIM_W) ? COL_W : DIM_W;
    localparam int   DIM_MAX = (1 << DIM_W) - 1;
    localparam int   DEPTH   = 3 * MAX_WIDTH;
    localparam int   ADDR_W  = $clog2(DEPTH);
    localparam dim_t W_CAP   = dim_t'((MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH);
    localparam dim_t H_CAP   = dim_t'((MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT);
    localparam dim_t W_RESET = dim_t'((RESET_WIDTH > int'(W_CAP)) ? int'(W_CAP) : RESET_WIDTH);
    localparam dim_t H_RESET = dim_t'((RESET_HEIGHT > int'(H_CAP)) ? int'(H_CAP) : RESET_HEIGHT);
    localparam cnt_t TOTAL_RESET = cnt_t'(int'(W_RESET) * int'(H_RESET));

    typedef logic [1:0]    slot_t;
    typedef logic [CW-1:0] col_idx_t;

    // dimension registers hold effective values, zero reads as one
    dim_t     w_reg, w_next;
    dim_t     h_reg, h_next;
    cnt_t     total_reg, total_next;

    // input position (received) and result position (emitted)
    cnt_t     rcv_reg, rcv_next;
    cnt_t     emt_reg, emt_next;
    col_idx_t wx_reg, wx_next;
    slot_t    wslot_reg, wslot_next;
    col_idx_t ex_reg, ex_next;
    dim_t     ey_reg, ey_next;
    slot_t    eslot_reg, eslot_next;

    logic     accept;
    logic     take;
    logic     clr0;
    cnt_t     r0, e0, r1, e1;
    col_idx_t wx0, ex0, w_last, rd_col;
    slot_t    wslot0, eslot0, rd_mid_slot, rd_top_slot;
    dim_t     ey0;
    logic     frame_in;
    logic     is_pix;
    logic     mem_we;
    logic     emit;
    logic     row_end;
    logic     border_now;
    logic     frame_end_now;
    pixel_t   pix_in;

    pixel_t   line_mem [DEPTH];
    pixel_t   rd_top_reg;
    pixel_t   rd_mid_reg;
    pixel_t   bot_reg;
    ctrl_t    s1_ctrl_reg, s1_ctrl_next;
    col_t     s1_col;

    function automatic dim_t clamp_dim(input dim_t v, input dim_t cap);
        if (v == '0)
        begin
            return dim_t'(1);
        end
        else if (v > cap)
        begin
            return cap;
        end
        return v;
    endfunction

    function automatic slot_t slot_inc(input slot_t s);
        return (s == slot_t'(2)) ? slot_t'(0) : s + slot_t'(1);
    endfunction

    function automatic slot_t slot_dec(input slot_t s);
        return (s == slot_t'(0)) ? slot_t'(2) : s - slot_t'(1);
    endfunction

    // three rows of MAX_WIDTH words, row y lives in slot y mod 3
    function automatic logic [ADDR_W-1:0] line_addr(input slot_t s, input col_idx_t c);
        logic [ADDR_W-1:0] base;
        case (s)
            slot_t'(1): base = ADDR_W'(MAX_WIDTH);
            slot_t'(2): base = ADDR_W'(2 * MAX_WIDTH);
            default:    base = '0;
        endcase
        return base + ADDR_W'(c[COL_W-1:0]);
    endfunction

    // ---------------------------------------------------------------
    // configuration: product of the dimensions is kept ready
    // ---------------------------------------------------------------
    always_comb
    begin
        w_next     = w_reg;
        h_next     = h_reg;
        total_next = total_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    w_next     = clamp_dim(cfg_wdata, W_CAP);
                    total_next = cnt_t'(w_next) * cnt_t'(h_reg);
                end
                REG_FRAME_HEIGHT:
                begin
                    h_next     = clamp_dim(cfg_wdata, H_CAP);
                    total_next = cnt_t'(w_reg) * cnt_t'(h_next);
                end
                default:
                begin
                    w_next = w_reg;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // position bookkeeping for the accepted word
    // ---------------------------------------------------------------
    assign accept = pixel_chan.valid && pixel_chan.ready;
    assign pixel_chan.ready = !s1_ctrl_reg.valid || take;
    assign is_pix = (pixel_chan.kind == KIND_PIXEL);
    assign pix_in = '{red: pixel_chan.pixel_red, green: pixel_chan.pixel_green,
                      blue: pixel_chan.pixel_blue};

    assign w_last = CW'(w_reg) - CW'(1);

    // counters restart if a new frame size already makes the frame complete
    assign clr0   = (emt_reg >= total_reg);
    assign r0     = clr0 ? '0 : rcv_reg;
    assign e0     = clr0 ? '0 : emt_reg;
    assign wx0    = clr0 ? '0 : wx_reg;
    assign wslot0 = clr0 ? '0 : wslot_reg;
    assign ex0    = clr0 ? '0 : ex_reg;
    assign ey0    = clr0 ? '0 : ey_reg;
    assign eslot0 = clr0 ? '0 : eslot_reg;
    assign r1     = r0 + cnt_t'(1);
    assign e1     = e0 + cnt_t'(1);

    assign frame_in = (r0 >= total_reg);
    assign row_end  = (ex0 >= w_last);

    assign border_now    = (ex0 == '0) || (ex0 == w_last) || (ey0 == '0)
                        || (ey0 >= h_reg - dim_t'(1));
    assign frame_end_now = (e0 == total_reg - cnt_t'(1));

    // the window column read for a result is the one after it; the bottom
    // of that column is the pixel arriving now
    assign rd_col      = row_end ? '0 : ex0 + CW'(1);
    assign rd_mid_slot = row_end ? slot_inc(eslot0) : eslot0;
    assign rd_top_slot = slot_dec(rd_mid_slot);

    always_comb
    begin
        rcv_next   = rcv_reg;
        emt_next   = emt_reg;
        wx_next    = wx_reg;
        wslot_next = wslot_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        eslot_next = eslot_reg;
        mem_we     = 1'b0;
        emit       = 1'b0;
        if (accept)
        begin
            rcv_next   = r0;
            emt_next   = e0;
            wx_next    = wx0;
            wslot_next = wslot0;
            ex_next    = ex0;
            ey_next    = ey0;
            eslot_next = eslot0;
            if (is_pix)
            begin
                // pixels past a complete frame are dropped
                if (!frame_in)
                begin
                    mem_we   = 1'b1;
                    rcv_next = r1;
                    if (wx0 >= w_last)
                    begin
                        wx_next    = '0;
                        wslot_next = slot_inc(wslot0);
                    end
                    else
                    begin
                        wx_next = wx0 + CW'(1);
                    end
                    emit = ((r1 - e0) > (cnt_t'(w_reg) + cnt_t'(1)));
                end
            end
            else
            begin
                // flush drains only once the whole frame is in
                emit = frame_in;
            end
            if (emit)
            begin
                if (e1 >= total_reg)
                begin
                    rcv_next   = '0;
                    emt_next   = '0;
                    wx_next    = '0;
                    wslot_next = '0;
                    ex_next    = '0;
                    ey_next    = '0;
                    eslot_next = '0;
                end
                else
                begin
                    emt_next = e1;
                    if (row_end)
                    begin
                        ex_next    = '0;
                        ey_next    = ey0 + dim_t'(1);
                        eslot_next = slot_inc(eslot0);
                    end
                    else
                    begin
                        ex_next = ex0 + CW'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        s1_ctrl_next = s1_ctrl_reg;
        if (emit)
        begin
            s1_ctrl_next = '{valid: 1'b1, border: border_now, frame_end: frame_end_now};
        end
        else if (take)
        begin
            s1_ctrl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= W_RESET;
            h_reg       <= H_RESET;
            total_reg   <= TOTAL_RESET;
            rcv_reg     <= '0;
            emt_reg     <= '0;
            wx_reg      <= '0;
            wslot_reg   <= '0;
            ex_reg      <= '0;
            ey_reg      <= '0;
            eslot_reg   <= '0;
            s1_ctrl_reg <= '0;
        end
        else
        begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            total_reg   <= total_next;
            rcv_reg     <= rcv_next;
            emt_reg     <= emt_next;
            wx_reg      <= wx_next;
            wslot_reg   <= wslot_next;
            ex_reg      <= ex_next;
            ey_reg      <= ey_next;
            eslot_reg   <= eslot_next;
            s1_ctrl_reg <= s1_ctrl_next;
        end
    end

    // ---------------------------------------------------------------
    // line store: one write, two registered reads
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[line_addr(wslot0, wx0)] <= pix_in;
        end
        if (emit)
        begin
            rd_top_reg <= line_mem[line_addr(rd_top_slot, rd_col)];
            rd_mid_reg <= line_mem[line_addr(rd_mid_slot, rd_col)];
            bot_reg    <= pix_in;
        end
    end

    assign s1_col = '{top: rd_top_reg, mid: rd_mid_reg, bot: bot_reg};

    lapedge_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .col       (s1_col),
        .ctrl      (s1_ctrl_reg),
        .take      (take),
        .edge_chan (edge_chan)
    );

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit && frame_end_now |=> (rcv_reg == '0) && (emt_reg == '0))
        else $error("counters not cleared after last result");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wslot_reg != 2'd3) && (eslot_reg != 2'd3))
        else $error("line slot out of range");

    a_column_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_ctrl_reg.valid && !take |=> $stable(rd_top_reg) && $stable(rd_mid_reg)
            && $stable(bot_reg))
        else $error("waiting column overwritten");
`endif

endmodule
